// ----- hdl/erpb_pkg.sv -----
// ----------------------------------------------------------------------------
// erpb_pkg
// Shared constants and types for the Euler point rotation pipeline.
// ----------------------------------------------------------------------------
package erpb_pkg;

   localparam int CORDIC_STEPS = 30;
   localparam int FRAC_BITS    = 30;          // Q2.30 trig and matrix format
   localparam int TURN_W       = 32;          // full turn = 2^32
   localparam int UNIT_W       = 32;          // clamped sin/cos, single products
   localparam int CX_W         = 33;          // CORDIC x/y datapath
   localparam int MAT_W        = 33;          // matrix entries (sum of two products)

   localparam int CORDIC_STAGES = CORDIC_STEPS + 2;   // prep + iterations + quadrant fix
   localparam int MAT_STAGES    = 3;
   localparam int ROT_STAGES    = 3;
   localparam int NUM_STAGES    = CORDIC_STAGES + MAT_STAGES + ROT_STAGES;

   localparam logic signed [CX_W-1:0]   CORDIC_GAIN = 33'sd652032874;
   localparam logic signed [UNIT_W-1:0] ONE_Q30     = 32'sd1073741824;
   localparam logic [TURN_W-1:0]        QUAD_HALF   = 32'h2000_0000;

   localparam logic signed [TURN_W-1:0] ATAN_TBL [CORDIC_STEPS] = '{
      32'sd536870912, 32'sd316933406, 32'sd167458907, 32'sd85004756, 32'sd42667331,
      32'sd21354465,  32'sd10679838,  32'sd5340245,   32'sd2670163,  32'sd1335087,
      32'sd667544,    32'sd333772,    32'sd166886,    32'sd83443,    32'sd41722,
      32'sd20861,     32'sd10430,     32'sd5215,      32'sd2608,     32'sd1304,
      32'sd652,       32'sd326,       32'sd163,       32'sd81,       32'sd41,
      32'sd20,        32'sd10,        32'sd5,         32'sd3,        32'sd1
   };

   typedef enum logic [1:0] {
      QUAD_0 = 2'd0,
      QUAD_1 = 2'd1,
      QUAD_2 = 2'd2,
      QUAD_3 = 2'd3
   } quad_type;

   typedef logic signed [MAT_W-1:0] mat_type [3][3];

endpackage

// ----- hdl/erpb_if.sv -----
// ----------------------------------------------------------------------------
// erpb_req_if / erpb_rsp_if
// Valid/ready channels for the request and the rotated result.
// ----------------------------------------------------------------------------
interface erpb_req_if #(
   parameter int COORD_WIDTH = 32,
   parameter int ANGLE_WIDTH = 16
);
   logic                          valid;
   logic                          ready;
   logic signed [ANGLE_WIDTH-1:0] roll_bam;
   logic signed [ANGLE_WIDTH-1:0] pitch_bam;
   logic signed [ANGLE_WIDTH-1:0] yaw_bam;
   logic signed [COORD_WIDTH-1:0] point_x;
   logic signed [COORD_WIDTH-1:0] point_y;
   logic signed [COORD_WIDTH-1:0] point_z;
   logic signed [COORD_WIDTH-1:0] base_x;
   logic signed [COORD_WIDTH-1:0] base_y;
   logic signed [COORD_WIDTH-1:0] base_z;

   modport source (output valid, roll_bam, pitch_bam, yaw_bam, point_x, point_y,
                   point_z, base_x, base_y, base_z, input ready);
   modport sink   (input valid, roll_bam, pitch_bam, yaw_bam, point_x, point_y,
                   point_z, base_x, base_y, base_z, output ready);
endinterface

interface erpb_rsp_if #(
   parameter int COORD_WIDTH = 32
);
   logic                          valid;
   logic                          ready;
   logic signed [COORD_WIDTH-1:0] rotated_x;
   logic signed [COORD_WIDTH-1:0] rotated_y;
   logic signed [COORD_WIDTH-1:0] rotated_z;
   logic                          saturated;

   modport source (output valid, rotated_x, rotated_y, rotated_z, saturated, input ready);
   modport sink   (input valid, rotated_x, rotated_y, rotated_z, saturated, output ready);
endinterface

// ----- hdl/erpb_cordic.sv -----
// ----------------------------------------------------------------------------
// erpb_cordic
// Pipelined rotation-mode CORDIC: one angle in, clamped Q2.30 cos/sin out.
// ----------------------------------------------------------------------------
module erpb_cordic
   import erpb_pkg::*;
#(
   parameter int ANGLE_WIDTH = 16
) (
   input  logic                          clock,
   input  logic [CORDIC_STAGES-1:0]      stage_en,
   input  logic signed [ANGLE_WIDTH-1:0] angle,
   output logic signed [UNIT_W-1:0]      cos_out,
   output logic signed [UNIT_W-1:0]      sin_out
);

   logic [TURN_W-1:0]        turn;
   logic [TURN_W-1:0]        turn_rnd;
   logic [1:0]               quad_in;
   logic [TURN_W-1:0]        resid_in;

   quad_type                 quad_ff [CORDIC_STEPS+1];
   logic signed [CX_W-1:0]   x_ff    [CORDIC_STEPS+1];
   logic signed [CX_W-1:0]   y_ff    [CORDIC_STEPS+1];
   logic signed [TURN_W-1:0] z_ff    [CORDIC_STEPS+1];

   logic signed [CX_W:0]     cos_raw, sin_raw;
   logic signed [UNIT_W-1:0] cos_ff, sin_ff;

   function automatic logic signed [UNIT_W-1:0] clamp_unit(input logic signed [CX_W:0] v);
      logic signed [CX_W:0] one_w;
      one_w = (CX_W+1)'(ONE_Q30);
      if (v > one_w)       return ONE_Q30;
      else if (v < -one_w) return -ONE_Q30;
      else                 return UNIT_W'(v);
   endfunction

   // quadrant split: q = round(turn / quarter), residual in [-1/8, 1/8) turn
   assign turn     = {angle, {(TURN_W-ANGLE_WIDTH){1'b0}}};
   assign turn_rnd = turn + QUAD_HALF;
   assign quad_in  = turn_rnd[TURN_W-1 -: 2];
   assign resid_in = turn - {quad_in, {(TURN_W-2){1'b0}}};

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         quad_ff[0] <= quad_type'(quad_in);
         x_ff[0]    <= CORDIC_GAIN;
         y_ff[0]    <= '0;
         z_ff[0]    <= $signed(resid_in);
      end
   end

   for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_iter
      logic signed [CX_W-1:0]   x_sh, y_sh, x_in, y_in;
      logic signed [TURN_W-1:0] z_in;

      assign x_sh = x_ff[i] >>> i;
      assign y_sh = y_ff[i] >>> i;

      always_comb begin
         if (!z_ff[i][TURN_W-1]) begin
            x_in = x_ff[i] - y_sh;
            y_in = y_ff[i] + x_sh;
            z_in = z_ff[i] - ATAN_TBL[i];
         end else begin
            x_in = x_ff[i] + y_sh;
            y_in = y_ff[i] - x_sh;
            z_in = z_ff[i] + ATAN_TBL[i];
         end
      end

      always_ff @(posedge clock) begin
         if (stage_en[i+1]) begin
            quad_ff[i+1] <= quad_ff[i];
            x_ff[i+1]    <= x_in;
            y_ff[i+1]    <= y_in;
            z_ff[i+1]    <= z_in;
         end
      end
   end

   always_comb begin
      unique case (quad_ff[CORDIC_STEPS])
         QUAD_0: begin
            cos_raw = (CX_W+1)'(x_ff[CORDIC_STEPS]);
            sin_raw = (CX_W+1)'(y_ff[CORDIC_STEPS]);
         end
         QUAD_1: begin
            cos_raw = -(CX_W+1)'(y_ff[CORDIC_STEPS]);
            sin_raw = (CX_W+1)'(x_ff[CORDIC_STEPS]);
         end
         QUAD_2: begin
            cos_raw = -(CX_W+1)'(x_ff[CORDIC_STEPS]);
            sin_raw = -(CX_W+1)'(y_ff[CORDIC_STEPS]);
         end
         default: begin
            cos_raw = (CX_W+1)'(y_ff[CORDIC_STEPS]);
            sin_raw = -(CX_W+1)'(x_ff[CORDIC_STEPS]);
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (stage_en[CORDIC_STAGES-1]) begin
         cos_ff <= clamp_unit(cos_raw);
         sin_ff <= clamp_unit(sin_raw);
      end
   end

   assign cos_out = cos_ff;
   assign sin_out = sin_ff;

endmodule

// ----- hdl/erpb_matrix.sv -----
// ----------------------------------------------------------------------------
// erpb_matrix
// Builds the y-up roll-pitch-yaw rotation matrix in Q2.30, three stages.
// ----------------------------------------------------------------------------
module erpb_matrix
   import erpb_pkg::*;
(
   input  logic                     clock,
   input  logic [MAT_STAGES-1:0]    stage_en,
   input  logic signed [UNIT_W-1:0] cr, sr, cp, sp, cy, sy,
   output mat_type                  mat
);

   // rounded Q2.30 product, round half up
   function automatic logic signed [UNIT_W-1:0] qmul(input logic signed [UNIT_W-1:0] a,
                                                     input logic signed [UNIT_W-1:0] b);
      logic signed [2*UNIT_W-1:0] p;
      p = a * b + (2*UNIT_W)'(64'sd1 <<< (FRAC_BITS-1));
      return p[FRAC_BITS +: UNIT_W];
   endfunction

   // stage 1: single products
   logic signed [UNIT_W-1:0] cycp_ff, cysp_ff, yssp_ff, cpcr_ff, cpsr_ff, yscp_ff;
   logic signed [UNIT_W-1:0] yssr_ff, yscr_ff, cysr_ff, cycr_ff;
   logic signed [UNIT_W-1:0] cr1_ff, sr1_ff, sp1_ff;
   // stage 2: second-level products
   logic signed [UNIT_W-1:0] cyspcr_ff, cyspsr_ff, ysspcr_ff, ysspsr_ff;
   logic signed [UNIT_W-1:0] cycp2_ff, cpcr2_ff, cpsr2_ff, yscp2_ff, sp2_ff;
   logic signed [UNIT_W-1:0] yssr2_ff, yscr2_ff, cysr2_ff, cycr2_ff;
   // stage 3: entries
   mat_type                  mat_ff;

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         cycp_ff <= qmul(cy, cp);
         cysp_ff <= qmul(cy, sp);
         yssp_ff <= qmul(sy, sp);
         cpcr_ff <= qmul(cp, cr);
         cpsr_ff <= qmul(cp, sr);
         yscp_ff <= qmul(sy, cp);
         yssr_ff <= qmul(sy, sr);
         yscr_ff <= qmul(sy, cr);
         cysr_ff <= qmul(cy, sr);
         cycr_ff <= qmul(cy, cr);
         cr1_ff  <= cr;
         sr1_ff  <= sr;
         sp1_ff  <= sp;
      end
      if (stage_en[1]) begin
         cyspcr_ff <= qmul(cysp_ff, cr1_ff);
         cyspsr_ff <= qmul(cysp_ff, sr1_ff);
         ysspcr_ff <= qmul(yssp_ff, cr1_ff);
         ysspsr_ff <= qmul(yssp_ff, sr1_ff);
         cycp2_ff  <= cycp_ff;
         cpcr2_ff  <= cpcr_ff;
         cpsr2_ff  <= cpsr_ff;
         yscp2_ff  <= yscp_ff;
         sp2_ff    <= sp1_ff;
         yssr2_ff  <= yssr_ff;
         yscr2_ff  <= yscr_ff;
         cysr2_ff  <= cysr_ff;
         cycr2_ff  <= cycr_ff;
      end
      if (stage_en[2]) begin
         mat_ff[0][0] <= MAT_W'(cycp2_ff);
         mat_ff[0][1] <= MAT_W'(yssr2_ff) - MAT_W'(cyspcr_ff);
         mat_ff[0][2] <= -MAT_W'(cyspsr_ff) - MAT_W'(yscr2_ff);
         mat_ff[1][0] <= MAT_W'(sp2_ff);
         mat_ff[1][1] <= MAT_W'(cpcr2_ff);
         mat_ff[1][2] <= MAT_W'(cpsr2_ff);
         mat_ff[2][0] <= MAT_W'(yscp2_ff);
         mat_ff[2][1] <= -MAT_W'(ysspcr_ff) - MAT_W'(cysr2_ff);
         mat_ff[2][2] <= MAT_W'(cycr2_ff) - MAT_W'(ysspsr_ff);
      end
   end

   assign mat = mat_ff;

endmodule

// ----- hdl/erpb_rotate.sv -----
// ----------------------------------------------------------------------------
// erpb_rotate
// Matrix times offset vector, exact rounding, base add-back and saturation.
// ----------------------------------------------------------------------------
module erpb_rotate
   import erpb_pkg::*;
#(
   parameter int COORD_WIDTH = 32
) (
   input  logic                          clock,
   input  logic [ROT_STAGES-1:0]         stage_en,
   input  mat_type                       mat,
   input  logic signed [COORD_WIDTH:0]   diff [3],
   input  logic signed [COORD_WIDTH-1:0] base [3],
   output logic signed [COORD_WIDTH-1:0] rotated [3],
   output logic                          saturated
);

   localparam int PROD_W = MAT_W + COORD_WIDTH + 1;
   localparam int SUM_W  = PROD_W + 2;
   localparam int ROW_W  = SUM_W - FRAC_BITS;
   localparam int VAL_W  = ROW_W + 1;

   logic signed [PROD_W-1:0]      prod_ff [3][3];
   logic signed [ROW_W-1:0]       row_ff  [3];
   logic signed [COORD_WIDTH-1:0] out_ff  [3];
   logic                          sat_ff;

   logic signed [SUM_W-1:0]       sum_in  [3];
   logic signed [COORD_WIDTH-1:0] out_in  [3];
   logic [2:0]                    clip;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         sum_in[i] = SUM_W'(prod_ff[i][0]) + SUM_W'(prod_ff[i][1]) + SUM_W'(prod_ff[i][2])
                   + (SUM_W'(1) <<< (FRAC_BITS-1));
      end
   end

   // add the base back and clip to the coordinate range
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         logic signed [VAL_W-1:0] v;
         v = VAL_W'(row_ff[i]) + VAL_W'(base[i]);
         if (!v[VAL_W-1] && (|v[VAL_W-2:COORD_WIDTH-1])) begin
            out_in[i] = {1'b0, {(COORD_WIDTH-1){1'b1}}};
            clip[i]   = 1'b1;
         end else if (v[VAL_W-1] && !(&v[VAL_W-2:COORD_WIDTH-1])) begin
            out_in[i] = {1'b1, {(COORD_WIDTH-1){1'b0}}};
            clip[i]   = 1'b1;
         end else begin
            out_in[i] = v[COORD_WIDTH-1:0];
            clip[i]   = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
               prod_ff[i][j] <= PROD_W'(mat[i][j]) * PROD_W'(diff[j]);
            end
         end
      end
      if (stage_en[1]) begin
         for (int i = 0; i < 3; i++) begin
            row_ff[i] <= sum_in[i][SUM_W-1:FRAC_BITS];
         end
      end
      if (stage_en[2]) begin
         out_ff <= out_in;
         sat_ff <= |clip;
      end
   end

   assign rotated   = out_ff;
   assign saturated = sat_ff;

endmodule

// ----- hdl/euler_rotate_point_about_base_top.sv -----
// ----------------------------------------------------------------------------
// euler_rotate_point_about_base_top
// Rotates a point about a base point by roll/pitch/yaw angles, fixed point.
//
//  channel  dir  handshake           payload
//  req      in   req.valid/ready     roll/pitch/yaw angle, point xyz, base xyz
//  rsp      out  rsp.valid/ready     rotated xyz, saturated flag
//
//  One item per cycle sustained while rsp.ready is high; 38 register stages
//  (32 CORDIC, 3 matrix, 3 rotate). The depth is set by the 30-step CORDIC
//  pipeline.
//  Synchronous active-high reset clears only the stage valid bits.
//  Each stage advances when it is empty or the stage after it advances, so
//  a stalled result only holds the pipe once every stage behind it is full.
// ----------------------------------------------------------------------------
module euler_rotate_point_about_base_top
   import erpb_pkg::*;
#(
   parameter int COORD_WIDTH = 32,
   parameter int ANGLE_WIDTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   erpb_req_if.sink    req,
   erpb_rsp_if.source  rsp
);

   localparam int MAT_BASE = CORDIC_STAGES;          // first matrix stage
   localparam int ROT_BASE = CORDIC_STAGES + MAT_STAGES;

   // stage control
   logic [NUM_STAGES-1:0] valid_ff;
   logic [NUM_STAGES-1:0] stage_en;

   always_comb begin
      stage_en[NUM_STAGES-1] = !valid_ff[NUM_STAGES-1] || rsp.ready;
      for (int k = NUM_STAGES-2; k >= 0; k--) begin
         stage_en[k] = !valid_ff[k] || stage_en[k+1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (stage_en[0]) valid_ff[0] <= req.valid;
         for (int k = 1; k < NUM_STAGES; k++) begin
            if (stage_en[k]) valid_ff[k] <= valid_ff[k-1];
         end
      end
   end

   assign req.ready = stage_en[0];

   // offset and base travel alongside the angle pipeline
   logic signed [COORD_WIDTH:0]   diff_ff [ROT_BASE][3];
   logic signed [COORD_WIDTH-1:0] base_ff [NUM_STAGES-1][3];

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         diff_ff[0][0] <= (COORD_WIDTH+1)'(req.point_x) - (COORD_WIDTH+1)'(req.base_x);
         diff_ff[0][1] <= (COORD_WIDTH+1)'(req.point_y) - (COORD_WIDTH+1)'(req.base_y);
         diff_ff[0][2] <= (COORD_WIDTH+1)'(req.point_z) - (COORD_WIDTH+1)'(req.base_z);
         base_ff[0][0] <= req.base_x;
         base_ff[0][1] <= req.base_y;
         base_ff[0][2] <= req.base_z;
      end
      for (int k = 1; k < ROT_BASE; k++) begin
         if (stage_en[k]) diff_ff[k] <= diff_ff[k-1];
      end
      for (int k = 1; k < NUM_STAGES-1; k++) begin
         if (stage_en[k]) base_ff[k] <= base_ff[k-1];
      end
   end

   // sine/cosine of the three angles
   logic signed [UNIT_W-1:0] cr, sr, cp, sp, cy, sy;

   erpb_cordic #(.ANGLE_WIDTH(ANGLE_WIDTH)) u_cordic_roll (
      .clock(clock), .stage_en(stage_en[CORDIC_STAGES-1:0]),
      .angle(req.roll_bam), .cos_out(cr), .sin_out(sr)
   );

   erpb_cordic #(.ANGLE_WIDTH(ANGLE_WIDTH)) u_cordic_pitch (
      .clock(clock), .stage_en(stage_en[CORDIC_STAGES-1:0]),
      .angle(req.pitch_bam), .cos_out(cp), .sin_out(sp)
   );

   erpb_cordic #(.ANGLE_WIDTH(ANGLE_WIDTH)) u_cordic_yaw (
      .clock(clock), .stage_en(stage_en[CORDIC_STAGES-1:0]),
      .angle(req.yaw_bam), .cos_out(cy), .sin_out(sy)
   );

   // rotation matrix
   mat_type mat;

   erpb_matrix u_matrix (
      .clock(clock), .stage_en(stage_en[MAT_BASE +: MAT_STAGES]),
      .cr(cr), .sr(sr), .cp(cp), .sp(sp), .cy(cy), .sy(sy),
      .mat(mat)
   );

   // apply to the offset and restore the base
   logic signed [COORD_WIDTH-1:0] rotated [3];
   logic                          saturated;

   erpb_rotate #(.COORD_WIDTH(COORD_WIDTH)) u_rotate (
      .clock(clock), .stage_en(stage_en[ROT_BASE +: ROT_STAGES]),
      .mat(mat), .diff(diff_ff[ROT_BASE-1]), .base(base_ff[NUM_STAGES-2]),
      .rotated(rotated), .saturated(saturated)
   );

   assign rsp.valid     = valid_ff[NUM_STAGES-1];
   assign rsp.rotated_x = rotated[0];
   assign rsp.rotated_y = rotated[1];
   assign rsp.rotated_z = rotated[2];
   assign rsp.saturated = saturated;

`ifndef NO_ASSERTIONS
   localparam logic signed [COORD_WIDTH-1:0] C_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
   localparam logic signed [COORD_WIDTH-1:0] C_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

   // a flagged result has at least one coordinate pinned to a range end
   a_sat_pinned: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.saturated |->
         rsp.rotated_x == C_MAX || rsp.rotated_x == C_MIN ||
         rsp.rotated_y == C_MAX || rsp.rotated_y == C_MIN ||
         rsp.rotated_z == C_MAX || rsp.rotated_z == C_MIN)
      else $error("saturated flag without a clipped coordinate");

   // an empty output stage never holds off the input
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !valid_ff[NUM_STAGES-1] |-> req.ready)
      else $error("input stalled with an empty output stage");

   // reset empties the pipeline
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp.valid && valid_ff == '0)
      else $error("pipeline not empty after reset");
`endif

endmodule

// ----- sim/euler_rotate_point_about_base_top_tb.sv -----
// ----------------------------------------------------------------------------
// euler_rotate_point_about_base_top_tb
// Self-checking bench for the Euler point rotation pipeline. A directed table
// of items (zero angles, angle extremes, coordinate extremes, saturation)
// is followed by random items, with random idling on both channels, a long
// result stall and a drain pause. Every result is checked field by field
// against an in-bench fixed-point predictor.
// ----------------------------------------------------------------------------
module euler_rotate_point_about_base_top_tb;
   import erpb_pkg::*;

   localparam int CW          = 32;
   localparam int AW          = 16;
   localparam int RANDOM_ITEMS = 1830;
   localparam int STALL_LIMIT = 5000;   // cycles with no handshake at all
   localparam int PIPE_LAT    = 38;

   typedef struct {
      logic signed [AW-1:0] ang [3];    // roll, pitch, yaw
      logic signed [CW-1:0] pnt [3];
      logic signed [CW-1:0] bas [3];
   } rot_item_type;

   typedef struct {
      logic signed [CW-1:0] crd [3];
      logic                 sat;
   } rot_result_type;

   // directed row: item plus optional typed-in result
   typedef struct {
      rot_item_type   item;
      bit             known;
      rot_result_type res;
   } dir_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   erpb_req_if #(.COORD_WIDTH(CW), .ANGLE_WIDTH(AW)) req_ch ();
   erpb_rsp_if #(.COORD_WIDTH(CW))                    rsp_ch ();

   euler_rotate_point_about_base_top #(.COORD_WIDTH(CW), .ANGLE_WIDTH(AW)) dut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch.sink),
      .rsp   (rsp_ch.source)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   rot_result_type rotated_queue [$];
   int          mismatch_count = 0;
   int          idle_cycles    = 0;
   bit          timed_out      = 1'b0;
   bit          hold_results   = 1'b0;   // long receiver stall request
   bit          no_idle        = 1'b0;   // stretch with no idling

   // ---------------------------------------------------------------------
   // Predictor
   // ---------------------------------------------------------------------
   // floor shift of a 128-bit signed value
   function automatic longint fshr(input logic signed [127:0] v, input int s);
      logic signed [127:0] t;
      t = v >>> s;
      return longint'(t);
   endfunction

   // sin/cos of a binary angle in Q2.30, via 30-step CORDIC
   function automatic void trig_of(input logic [AW-1:0] ang,
                                   output longint cv, output longint sv);
      logic [31:0]        turn, resid;
      logic [1:0]         quad;
      longint             x, y, z, nx, ny;
      turn  = {ang, {(32-AW){1'b0}}};
      quad  = 2'((turn + QUAD_HALF) >> 30);
      resid = turn - {quad, 30'd0};
      z = longint'($signed(resid));
      x = 64'sd652032874;
      y = 0;
      for (int i = 0; i < CORDIC_STEPS; i++) begin
         if (z >= 0) begin
            nx = x - (y >>> i); ny = y + (x >>> i); z -= longint'(ATAN_TBL[i]);
         end else begin
            nx = x + (y >>> i); ny = y - (x >>> i); z += longint'(ATAN_TBL[i]);
         end
         x = nx; y = ny;
      end
      case (quad_type'(quad))
         QUAD_0: begin cv = x;  sv = y;  end
         QUAD_1: begin cv = -y; sv = x;  end
         QUAD_2: begin cv = -x; sv = -y; end
         default: begin cv = y; sv = -x; end
      endcase
      if (cv > 64'sd1073741824) cv = 64'sd1073741824;
      if (cv < -64'sd1073741824) cv = -64'sd1073741824;
      if (sv > 64'sd1073741824) sv = 64'sd1073741824;
      if (sv < -64'sd1073741824) sv = -64'sd1073741824;
   endfunction

   function automatic longint qmul(input longint a, input longint b);
      return (a * b + 64'sd536870912) >>> FRAC_BITS;
   endfunction

   function automatic rot_result_type rotate_point(input rot_item_type it);
      rot_result_type      r;
      longint              cr, sr, cp, sp, cy, sy;
      longint              m [3][3];
      longint              d [3];
      logic signed [127:0] acc;
      longint              v;
      longint              hi_lim, lo_lim;
      hi_lim = 64'sd2147483647;
      lo_lim = -64'sd2147483648;
      trig_of(it.ang[0], cr, sr);
      trig_of(it.ang[1], cp, sp);
      trig_of(it.ang[2], cy, sy);
      m[0][0] = qmul(cy, cp);
      m[0][1] = -qmul(qmul(cy, sp), cr) + qmul(sy, sr);
      m[0][2] = -qmul(qmul(cy, sp), sr) - qmul(sy, cr);
      m[1][0] = sp;
      m[1][1] = qmul(cp, cr);
      m[1][2] = qmul(cp, sr);
      m[2][0] = qmul(sy, cp);
      m[2][1] = -qmul(qmul(sy, sp), cr) - qmul(cy, sr);
      m[2][2] = -qmul(qmul(sy, sp), sr) + qmul(cy, cr);
      for (int j = 0; j < 3; j++)
         d[j] = longint'(it.pnt[j]) - longint'(it.bas[j]);
      r.sat = 1'b0;
      for (int i = 0; i < 3; i++) begin
         acc = 128'sd536870912;
         for (int j = 0; j < 3; j++)
            acc += 128'(signed'(m[i][j])) * 128'(signed'(d[j]));
         v = fshr(acc, FRAC_BITS) + longint'(it.bas[i]);
         if (v > hi_lim) begin v = hi_lim; r.sat = 1'b1; end
         if (v < lo_lim) begin v = lo_lim; r.sat = 1'b1; end
         r.crd[i] = CW'(v);
      end
      return r;
   endfunction

   // ---------------------------------------------------------------------
   // Sender: drives at the falling edge, item taken at rising edge
   // ---------------------------------------------------------------------
   initial begin
      req_ch.valid       = 1'b0;
      req_ch.roll_bam    = '0;
      req_ch.pitch_bam   = '0;
      req_ch.yaw_bam     = '0;
      req_ch.point_x     = '0;
      req_ch.point_y     = '0;
      req_ch.point_z     = '0;
      req_ch.base_x      = '0;
      req_ch.base_y      = '0;
      req_ch.base_z      = '0;
      rsp_ch.ready       = 1'b0;
   end

   // drives one item, waits for its handshake, records the expectation
   task automatic send_item(input rot_item_type it, input bit known,
                            input rot_result_type res);
      rot_result_type pred;
      pred = rotate_point(it);
      req_ch.valid       <= 1'b1;
      req_ch.roll_bam    <= it.ang[0];
      req_ch.pitch_bam   <= it.ang[1];
      req_ch.yaw_bam     <= it.ang[2];
      req_ch.point_x     <= it.pnt[0];
      req_ch.point_y     <= it.pnt[1];
      req_ch.point_z     <= it.pnt[2];
      req_ch.base_x      <= it.bas[0];
      req_ch.base_y      <= it.bas[1];
      req_ch.base_z      <= it.bas[2];
      do @(posedge clock); while (!req_ch.ready);
      // the typed-in value must agree with the predictor too
      if (known && (pred.crd != res.crd || pred.sat != res.sat)) begin
         mismatch_count++;
         if (mismatch_count <= 10)
            $display("table row: exp %0d %0d %0d sat %0b, predicted %0d %0d %0d sat %0b",
                     res.crd[0], res.crd[1], res.crd[2], res.sat,
                     pred.crd[0], pred.crd[1], pred.crd[2], pred.sat);
      end
      rotated_queue.push_back(known ? res : pred);
      @(negedge clock);
      // random gap before the next item; the valid stays high otherwise
      if (!no_idle && $urandom_range(99) < 18) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(negedge clock);
      end
   endtask

   function automatic logic signed [CW-1:0] rand_coord();
      case ($urandom_range(5))
         0: return $signed($urandom());
         1: return 32'sh7FFF_FFFF - $urandom_range(3);
         2: return 32'sh8000_0000 + $urandom_range(3);
         default: return $signed($urandom()) >>> $urandom_range(8, 20);
      endcase
   endfunction

   function automatic logic signed [AW-1:0] rand_angle();
      case ($urandom_range(7))
         0: return AW'($urandom_range(3) << (AW-2));   // quadrant boundaries
         1: return AW'(($urandom_range(7) << (AW-3)) + $urandom_range(2) - 1);
         default: return AW'($urandom());
      endcase
   endfunction

   function automatic rot_item_type rand_item();
      rot_item_type it;
      for (int k = 0; k < 3; k++) begin
         it.ang[k] = rand_angle();
         it.pnt[k] = rand_coord();
         it.bas[k] = ($urandom_range(3) == 0) ? '0 : rand_coord();
      end
      return it;
   endfunction

   function automatic rot_item_type mk_item(input int r, p, y,
                                            input logic signed [CW-1:0] px, py, pz,
                                            input logic signed [CW-1:0] bx, by, bz);
      rot_item_type it;
      it.ang = '{AW'(r), AW'(p), AW'(y)};
      it.pnt = '{px, py, pz};
      it.bas = '{bx, by, bz};
      return it;
   endfunction

   dir_row_type    dir_table [$];
   rot_result_type no_res;

   initial begin
      localparam logic signed [CW-1:0] CMAX = 32'sh7FFF_FFFF;
      localparam logic signed [CW-1:0] CMIN = 32'sh8000_0000;
      localparam logic signed [CW-1:0] ONE  = 32'sh0001_0000;
      dir_row_type row;
      no_res.crd = '{0, 0, 0};
      no_res.sat = 1'b0;

      // zero angles with the identity: point returned as is
      row = '{mk_item(0, 0, 0, ONE, -ONE, 32'sh0003_8000, 0, 0, 0), 1'b1,
              '{'{ONE, -ONE, 32'sh0003_8000}, 1'b0}};
      dir_table.push_back(row);
      // point equal to base: base returned, any angles
      row = '{mk_item(16'h1234, 16'h8000, 16'h7FFF, CMAX, CMIN, ONE, CMAX, CMIN, ONE),
              1'b1, '{'{CMAX, CMIN, ONE}, 1'b0}};
      dir_table.push_back(row);
      // coordinate extremes, zero rotation
      row = '{mk_item(0, 0, 0, CMAX, CMIN, CMAX, 0, 0, 0), 1'b0, no_res};
      dir_table.push_back(row);
      // extremes with a far base: saturation both ways
      row = '{mk_item(16'h8000, 0, 0, CMAX, CMAX, CMIN, CMIN, CMIN, CMAX),
              1'b0, no_res};
      dir_table.push_back(row);
      row = '{mk_item(0, 16'h8000, 16'h8000, CMIN, CMAX, CMAX, CMAX, CMIN, CMIN),
              1'b0, no_res};
      dir_table.push_back(row);
      // angle extremes and quadrant boundaries on each axis
      for (int k = 0; k < 3; k++) begin
         int angs [6];
         angs = '{16'h7FFF, 16'h8000, 16'h4000, 16'hC000, 16'h2000, 16'h0001};
         for (int a = 0; a < 6; a++) begin
            rot_item_type it;
            it = mk_item(0, 0, 0, ONE, 32'sh0002_0000, 32'sh0003_0000, 0, 0, 0);
            it.ang[k] = AW'(angs[a]);
            if (a == 5) it.bas = '{-ONE, ONE, CMIN};
            row = '{it, 1'b0, no_res};
            dir_table.push_back(row);
         end
      end
      // all-ones-ish operands to toggle every bit
      row = '{mk_item(16'hFFFF, 16'h5555, 16'hAAAA, -1, 32'sh5555_5555, 32'shAAAA_AAAA,
                      32'sh5555_5555, -1, 32'sh2AAA_AAAA), 1'b0, no_res};
      dir_table.push_back(row);

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (dir_table[i])
         send_item(dir_table[i].item, dir_table[i].known, dir_table[i].res);

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         // long receiver hold-off while items keep coming
         if (n == 300) hold_results = 1'b1;
         // pause until the pipe drains
         if (n == 700) begin
            req_ch.valid <= 1'b0;
            while (rotated_queue.size() != 0) @(negedge clock);
         end
         no_idle = (n >= 1000 && n < 1250);
         send_item(rand_item(), 1'b0, no_res);
      end
      req_ch.valid <= 1'b0;

      while (rotated_queue.size() != 0) @(negedge clock);
      repeat (PIPE_LAT + 10) @(negedge clock);
      if (mismatch_count == 0 && !timed_out)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // ---------------------------------------------------------------------
   // Receiver: random ready with a long counted stall
   // ---------------------------------------------------------------------
   initial begin
      int hold_count;
      hold_count = 0;
      @(negedge clock);
      while (1) begin
         if (hold_results) begin
            rsp_ch.ready <= 1'b0;
            hold_count++;
            if (hold_count == 200) hold_results = 1'b0;
         end else
            rsp_ch.ready <= no_idle || ($urandom_range(99) >= 18);
         @(negedge clock);
      end
   end

   // result check at the rising edge
   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         rot_result_type exp_r;
         if (rotated_queue.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected result: %0d %0d %0d", rsp_ch.rotated_x,
                        rsp_ch.rotated_y, rsp_ch.rotated_z);
         end else begin
            exp_r = rotated_queue.pop_front();
            if (rsp_ch.rotated_x !== exp_r.crd[0] || rsp_ch.rotated_y !== exp_r.crd[1] ||
                rsp_ch.rotated_z !== exp_r.crd[2] || rsp_ch.saturated !== exp_r.sat) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("mismatch: exp %0d %0d %0d sat %0b, got %0d %0d %0d sat %0b",
                           exp_r.crd[0], exp_r.crd[1], exp_r.crd[2], exp_r.sat,
                           rsp_ch.rotated_x, rsp_ch.rotated_y, rsp_ch.rotated_z,
                           rsp_ch.saturated);
            end
         end
      end
   end

   // watchdog: cycles with no handshake on either side
   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles == STALL_LIMIT) begin
         timed_out = 1'b1;
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

endmodule
